### hdl/bpa_pkg.sv
// bpa_pkg: shared types and constants of the bitmap page allocator.
// No dependencies; compiled first.
package bpa_pkg;

  localparam int DEF_PAGES   = 4096;
  localparam int WORD_BITS   = 8;
  localparam int LANE_W      = 3;
  localparam int OP_W        = 2;
  localparam int FP_W        = 12;
  localparam int CNT_W       = 13;
  localparam logic [CNT_W-1:0] LIMIT_RESET = 13'h1000;

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_ADD   = 2'd2
  } op_t;

  typedef enum logic {
    STS_OK  = 1'b0,
    STS_OOM = 1'b1
  } status_t;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_SCAN_SET,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_SW_SET,
    ST_SW_RD,
    ST_SW_WR,
    ST_DONE
  } state_t;

endpackage

### hdl/bpa_if.sv
// Valid/ready channel interfaces of the page allocator: request, response, config.
// Depends on bpa_pkg.
interface bpa_req_if import bpa_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  operation;
  logic [FP_W-1:0]  first_page;
  logic [CNT_W-1:0] page_count;
  modport source (output valid, operation, first_page, page_count, input ready);
  modport sink   (input valid, operation, first_page, page_count, output ready);
endinterface

interface bpa_rsp_if import bpa_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             status;
  logic [FP_W-1:0]  alloc_page;
  logic [CNT_W-1:0] free_pages;
  logic [CNT_W-1:0] used_pages;
  modport source (output valid, status, alloc_page, free_pages, used_pages, input ready);
  modport sink   (input valid, status, alloc_page, free_pages, used_pages, output ready);
endinterface

interface bpa_cfg_if import bpa_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

### hdl/bitmap_page_allocator.sv
// Next-fit bitmap page allocator, top level. Depends on bpa_pkg, bpa_if, bpa_ram, bpa_scan.
// Allocate scans the map one 8-page word at a time (up to two passes, the second from
// page zero up to the old cursor), then marks the found run word by word; free and add
// read/modify/write each word touched; an item with no work goes straight to ST_DONE.
// One item at a time; the bitmap RAM read/modify/write sets the pace.
// Reset: synchronous; a clearing pass over every map word fills the map with ones,
// with req.ready low meanwhile. Config writes are taken at any time.
module bitmap_page_allocator import bpa_pkg::*; #(
  parameter int PAGES = DEF_PAGES
) (
  input logic       clk,
  input logic       rst,
  bpa_req_if.sink   req,
  bpa_rsp_if.source rsp,
  bpa_cfg_if.sink   cfg
);
  localparam int CW    = $clog2(PAGES + 1);
  localparam int XW    = (CW > CNT_W ? CW : CNT_W) + 1;
  localparam int DEPTH = (PAGES + WORD_BITS - 1) / WORD_BITS;
  localparam int AW    = DEPTH > 1 ? $clog2(DEPTH) : 1;
  localparam logic [XW-1:0] PAGES_X = XW'(PAGES);

  // control and bookkeeping
  state_t           state, state_next;
  logic [CNT_W-1:0] page_limit;
  logic [XW-1:0]    cursor, cursor_next;
  logic [XW-1:0]    free_cnt, free_cnt_next;
  logic [XW-1:0]    used_cnt, used_cnt_next;
  logic             pass, pass_next;
  logic [AW-1:0]    wa, wa_next;
  logic [AW-1:0]    wa_last, wa_last_next;
  // working payload
  logic [XW-1:0]    cnt, cnt_next;
  logic [XW-1:0]    rs, rs_next;
  logic [XW-1:0]    re, re_next;
  logic [XW-1:0]    run, run_next;
  logic             set_val, set_val_next;
  logic             res_status, res_status_next;
  logic [FP_W-1:0]  res_page, res_page_next;
  // response register
  logic             rsp_valid, rsp_valid_next;
  logic             rsp_load;

  logic                 ram_we;
  logic [WORD_BITS-1:0] ram_wdata, ram_rdata, merged;
  logic [XW-1:0]        base;
  logic                 scan_hit;
  logic [XW-1:0]        scan_fp, scan_run;

  logic [XW-1:0] in_first, in_cnt, in_end, add_start, n_free, n_add, lim_eff, lim_x;

  function automatic logic [XW-1:0] sat_add(input logic [XW-1:0] a, input logic [XW-1:0] b);
    logic [XW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return (s > {1'b0, PAGES_X}) ? PAGES_X : s[XW-1:0];
  endfunction

  function automatic logic [XW-1:0] sat_sub(input logic [XW-1:0] a, input logic [XW-1:0] b);
    return (a > b) ? a - b : '0;
  endfunction

  // request decode helpers; runs past the map are clipped at PAGES
  always_comb begin
    logic [XW-1:0] e;
    in_first  = XW'(req.first_page);
    in_cnt    = XW'(req.page_count);
    e         = in_first + in_cnt;
    in_end    = (e > PAGES_X) ? PAGES_X : e;
    add_start = (in_first == '0) ? XW'(1) : in_first;
    n_free    = (in_end > in_first) ? in_end - in_first : '0;
    n_add     = (in_end > add_start) ? in_end - add_start : '0;
    lim_x     = XW'(page_limit);
    lim_eff   = (lim_x < PAGES_X) ? lim_x : PAGES_X;
  end

  // bitmap storage, one word of pages per entry
  bpa_ram #(.WIDTH(WORD_BITS), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wa),
    .wdata (ram_wdata),
    .raddr (wa),
    .rdata (ram_rdata)
  );

  assign base = XW'({wa, LANE_W'(0)});

  bpa_scan #(.XW(XW)) u_scan (
    .word    (ram_rdata),
    .base    (base),
    .rs      (rs),
    .re      (re),
    .cnt     (cnt),
    .run_in  (run),
    .hit     (scan_hit),
    .fp      (scan_fp),
    .run_out (scan_run)
  );

  // read-modify-write merge: pages in [rs, re) take set_val
  always_comb begin
    logic [XW-1:0] pg;
    for (int j = 0; j < WORD_BITS; j++) begin
      pg = base + XW'(j);
      merged[j] = (pg >= rs && pg < re) ? set_val : ram_rdata[j];
    end
  end

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_INIT;
      page_limit <= LIMIT_RESET;
      cursor     <= '0;
      free_cnt   <= '0;
      used_cnt   <= '0;
      wa         <= '0;
      pass       <= 1'b0;
      rsp_valid  <= 1'b0;
    end else begin
      state     <= state_next;
      cursor    <= cursor_next;
      free_cnt  <= free_cnt_next;
      used_cnt  <= used_cnt_next;
      wa        <= wa_next;
      pass      <= pass_next;
      rsp_valid <= rsp_valid_next;
      if (cfg.valid) begin
        page_limit <= cfg.data;
      end
    end
  end

  always_ff @(posedge clk) begin
    wa_last    <= wa_last_next;
    cnt        <= cnt_next;
    rs         <= rs_next;
    re         <= re_next;
    run        <= run_next;
    set_val    <= set_val_next;
    res_status <= res_status_next;
    res_page   <= res_page_next;
    if (rsp_load) begin
      rsp.status     <= res_status;
      rsp.alloc_page <= res_page;
      rsp.free_pages <= free_cnt[CNT_W-1:0];
      rsp.used_pages <= used_cnt[CNT_W-1:0];
    end
  end

  assign rsp.valid = rsp_valid;

  always_comb begin
    state_next      = state;
    cursor_next     = cursor;
    free_cnt_next   = free_cnt;
    used_cnt_next   = used_cnt;
    wa_next         = wa;
    wa_last_next    = wa_last;
    pass_next       = pass;
    cnt_next        = cnt;
    rs_next         = rs;
    re_next         = re;
    run_next        = run;
    set_val_next    = set_val;
    res_status_next = res_status;
    res_page_next   = res_page;
    rsp_valid_next  = rsp_valid && !rsp.ready;
    rsp_load        = 1'b0;
    ram_we          = 1'b0;
    ram_wdata       = merged;
    req.ready       = 1'b0;

    unique case (state)
      ST_INIT: begin
        // clearing pass: every page starts out used
        ram_we    = 1'b1;
        ram_wdata = '1;
        if (wa == AW'(DEPTH - 1)) begin
          wa_next    = '0;
          state_next = ST_IDLE;
        end else begin
          wa_next = wa + AW'(1);
        end
      end

      ST_IDLE: begin
        req.ready = 1'b1;
        if (req.valid) begin
          res_status_next = STS_OK;
          res_page_next   = '0;
          cnt_next        = in_cnt;
          state_next      = ST_DONE;
          case (req.operation)
            OP_ALLOC: begin
              if (in_cnt == '0) begin
                res_status_next = STS_OOM;
              end else begin
                pass_next  = 1'b0;
                rs_next    = cursor;
                re_next    = lim_eff;
                run_next   = '0;
                state_next = ST_SCAN_SET;
              end
            end
            OP_FREE: begin
              // a free of the null page does nothing
              if (in_first != '0) begin
                used_cnt_next = sat_sub(used_cnt, n_free);
                free_cnt_next = sat_add(free_cnt, n_free);
                if (cursor > in_first) begin
                  cursor_next = in_first;
                end
                if (n_free != '0) begin
                  rs_next      = in_first;
                  re_next      = in_end;
                  set_val_next = 1'b0;
                  state_next   = ST_SW_SET;
                end
              end
            end
            OP_ADD: begin
              free_cnt_next = sat_add(free_cnt, n_add);
              if (n_add != '0) begin
                rs_next      = add_start;
                re_next      = in_end;
                set_val_next = 1'b0;
                state_next   = ST_SW_SET;
              end
            end
            default: ;
          endcase
        end
      end

      ST_SCAN_SET: begin
        if (rs >= re) begin
          // empty pass
          if (!pass) begin
            pass_next = 1'b1;
            rs_next   = '0;
            re_next   = (cursor < PAGES_X) ? cursor : PAGES_X;
            run_next  = '0;
          end else begin
            res_status_next = STS_OOM;
            state_next      = ST_DONE;
          end
        end else begin
          wa_next      = AW'(rs >> LANE_W);
          wa_last_next = AW'((re - XW'(1)) >> LANE_W);
          state_next   = ST_SCAN_RD;
        end
      end

      ST_SCAN_RD: state_next = ST_SCAN_CHK;

      ST_SCAN_CHK: begin
        run_next = scan_run;
        if (scan_hit) begin
          res_page_next = FP_W'(scan_fp);
          cursor_next   = scan_fp + cnt;
          used_cnt_next = sat_add(used_cnt, cnt);
          free_cnt_next = sat_sub(free_cnt, cnt);
          rs_next       = scan_fp;
          re_next       = scan_fp + cnt;
          set_val_next  = 1'b1;
          state_next    = ST_SW_SET;
        end else if (wa == wa_last) begin
          if (!pass) begin
            // wrap: second pass from page zero up to the old cursor
            pass_next  = 1'b1;
            rs_next    = '0;
            re_next    = (cursor < PAGES_X) ? cursor : PAGES_X;
            run_next   = '0;
            state_next = ST_SCAN_SET;
          end else begin
            res_status_next = STS_OOM;
            state_next      = ST_DONE;
          end
        end else begin
          wa_next    = wa + AW'(1);
          state_next = ST_SCAN_RD;
        end
      end

      ST_SW_SET: begin
        wa_next      = AW'(rs >> LANE_W);
        wa_last_next = AW'((re - XW'(1)) >> LANE_W);
        state_next   = ST_SW_RD;
      end

      ST_SW_RD: state_next = ST_SW_WR;

      ST_SW_WR: begin
        ram_we = 1'b1;
        if (wa == wa_last) begin
          state_next = ST_DONE;
        end else begin
          wa_next    = wa + AW'(1);
          state_next = ST_SW_RD;
        end
      end

      ST_DONE: begin
        // result waits here only while the previous beat is still held
        if (!rsp_valid || rsp.ready) begin
          rsp_load       = 1'b1;
          rsp_valid_next = 1'b1;
          state_next     = ST_IDLE;
        end
      end

      default: state_next = ST_IDLE;
    endcase
  end

  // counts never leave [0, PAGES]
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    (free_cnt <= PAGES_X) && (used_cnt <= PAGES_X))
    else $error("page count out of range");

  // a found run never covers the null page nor runs past the pass end
  a_hit_bounds: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN_CHK && scan_hit) |-> (scan_fp != '0 && scan_fp + cnt <= re))
    else $error("run found outside the scanned range");

  // no request is taken during the clearing pass
  a_init_block: assert property (@(posedge clk) rst |=> !req.ready)
    else $error("request taken before the map was cleared");

endmodule

### hdl/bpa_ram.sv
// bpa_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module bpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### hdl/bpa_scan.sv
// bpa_scan: free-run search over one bitmap word, lane by lane.
// Depends on bpa_pkg.
module bpa_scan import bpa_pkg::*; #(
  parameter int XW = 14
) (
  input  logic [WORD_BITS-1:0] word,
  input  logic [XW-1:0]        base,
  input  logic [XW-1:0]        rs,
  input  logic [XW-1:0]        re,
  input  logic [XW-1:0]        cnt,
  input  logic [XW-1:0]        run_in,
  output logic                 hit,
  output logic [XW-1:0]        fp,
  output logic [XW-1:0]        run_out
);
  always_comb begin
    logic [XW-1:0] pg;
    logic [XW-1:0] r;
    r   = run_in;
    hit = 1'b0;
    fp  = '0;
    for (int j = 0; j < WORD_BITS; j++) begin
      pg = base + XW'(j);
      if (pg >= rs && pg < re && !hit) begin
        // page zero is null and never handed out
        if (word[j] || pg == '0) begin
          r = '0;
        end else begin
          r = r + XW'(1);
          if (r == cnt) begin
            hit = 1'b1;
            fp  = pg + XW'(1) - cnt;
          end
        end
      end
    end
    run_out = r;
  end
endmodule
